### src/prb_pkg.sv
// Types and constants shared by the inverse relationship matrix builder.
`default_nettype none
package prb_pkg;

    localparam int ANIMALS_DEF = 64;
    localparam int IDX_W       = 7;
    localparam int DELTA_W     = 5;
    localparam int VAL_W       = 16;
    localparam int OPS         = 6;
    localparam int OPS_W       = 3;
    localparam int CMDQ_DEPTH  = 2;

    localparam logic signed [VAL_W-1:0] VAL_ONE = 16'sd6;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 16'sh7FFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 16'sh8000;

    localparam logic signed [DELTA_W-1:0] D_DIAG_BOTH = 5'sd12;
    localparam logic signed [DELTA_W-1:0] D_PAIR_BOTH = -5'sd6;
    localparam logic signed [DELTA_W-1:0] D_PAR_BOTH  = 5'sd3;
    localparam logic signed [DELTA_W-1:0] D_DIAG_ONE  = 5'sd8;
    localparam logic signed [DELTA_W-1:0] D_PAIR_ONE  = -5'sd4;
    localparam logic signed [DELTA_W-1:0] D_PAR_ONE   = 5'sd2;

    typedef struct packed {
        logic       action;
        logic [5:0] animal_index;
        logic [6:0] sire_code;
        logic [6:0] dam_code;
        logic [5:0] read_row;
        logic [5:0] read_col;
    } t_in_beat;

    typedef struct packed {
        logic signed [15:0] entry_value;
        logic               saturated;
    } t_out_beat;

    typedef enum logic [1:0] {
        K_ZERO,
        K_READ,
        K_SET,
        K_BUMP
    } t_kind;

    typedef struct packed {
        logic [IDX_W-1:0]          a;
        logic [IDX_W-1:0]          b;
        logic signed [DELTA_W-1:0] delta;
    } t_op;

    typedef struct packed {
        t_kind              kind;
        logic [OPS_W-1:0]   last;
        t_op [OPS-1:0]      ops;
    } t_cmd;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_RD,
        ST_RDDATA,
        ST_WR,
        ST_DONE
    } t_state;

endpackage
`default_nettype wire

### src/prb_ram.sv
// Generic single write port, single read port RAM with registered read.
`default_nettype none
module prb_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

### src/prb_front.sv
// Front end: classifies an input beat into a command with its update list.
`default_nettype none
module prb_front #(
    parameter int ANIMALS = prb_pkg::ANIMALS_DEF
) (
    input  wire prb_pkg::t_in_beat i_beat,
    output prb_pkg::t_cmd          o_cmd
);

    localparam logic [8:0] ANIM9 = 9'(ANIMALS);

    logic                          x_ok;
    logic                          rd_ok;
    logic                          s_known;
    logic                          d_known;
    logic                          s_ok;
    logic                          d_ok;
    logic [prb_pkg::IDX_W-1:0]     x;
    logic [prb_pkg::IDX_W-1:0]     s;
    logic [prb_pkg::IDX_W-1:0]     d;
    logic [prb_pkg::IDX_W-1:0]     p;

    always_comb begin
        x       = prb_pkg::IDX_W'(i_beat.animal_index);
        s       = i_beat.sire_code - 7'd1;
        d       = i_beat.dam_code - 7'd1;
        s_known = i_beat.sire_code != 7'd0;
        d_known = i_beat.dam_code != 7'd0;
        p       = s_known ? s : d;
        x_ok    = 9'(i_beat.animal_index) < ANIM9;
        s_ok    = !s_known || (9'(s) < ANIM9);
        d_ok    = !d_known || (9'(d) < ANIM9);
        rd_ok   = (9'(i_beat.read_row) < ANIM9) && (9'(i_beat.read_col) < ANIM9);

        o_cmd      = '0;
        o_cmd.kind = prb_pkg::K_ZERO;
        if (i_beat.action) begin
            if (rd_ok) begin
                o_cmd.kind     = prb_pkg::K_READ;
                o_cmd.ops[0].a = prb_pkg::IDX_W'(i_beat.read_row);
                o_cmd.ops[0].b = prb_pkg::IDX_W'(i_beat.read_col);
            end
        end else if (x_ok && s_ok && d_ok) begin
            if (!s_known && !d_known) begin
                o_cmd.kind     = prb_pkg::K_SET;
                o_cmd.ops[0].a = x;
                o_cmd.ops[0].b = x;
            end else if (s_known && d_known) begin
                o_cmd.kind   = prb_pkg::K_BUMP;
                o_cmd.last   = prb_pkg::OPS_W'(5);
                o_cmd.ops[0] = '{a: x, b: x, delta: prb_pkg::D_DIAG_BOTH};
                o_cmd.ops[1] = '{a: x, b: s, delta: prb_pkg::D_PAIR_BOTH};
                o_cmd.ops[2] = '{a: d, b: x, delta: prb_pkg::D_PAIR_BOTH};
                o_cmd.ops[3] = '{a: s, b: s, delta: prb_pkg::D_PAR_BOTH};
                o_cmd.ops[4] = '{a: s, b: d, delta: prb_pkg::D_PAR_BOTH};
                o_cmd.ops[5] = '{a: d, b: d, delta: prb_pkg::D_PAR_BOTH};
            end else begin
                o_cmd.kind   = prb_pkg::K_BUMP;
                o_cmd.last   = prb_pkg::OPS_W'(2);
                o_cmd.ops[0] = '{a: x, b: x, delta: prb_pkg::D_DIAG_ONE};
                o_cmd.ops[1] = '{a: x, b: p, delta: prb_pkg::D_PAIR_ONE};
                o_cmd.ops[2] = '{a: p, b: p, delta: prb_pkg::D_PAR_ONE};
            end
        end
    end

endmodule
`default_nettype wire

### src/prb_cmd_fifo.sv
// Short command queue between the front end and the back end.
`default_nettype none
module prb_cmd_fifo #(
    parameter int DEPTH = prb_pkg::CMDQ_DEPTH
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire prb_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output prb_pkg::t_cmd      o_head,
    output logic               o_empty,
    output logic               o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    prb_pkg::t_cmd  r_slot [DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [CW-1:0]  r_count;

    assign o_head  = r_slot[r_rptr];
    assign o_empty = r_count == CW'(0);
    assign o_full  = r_count == CW'(DEPTH);

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + PW'(1);
            end
            if (i_pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

endmodule
`default_nettype wire

### src/prb_back.sv
// Back end: clears the store, runs read-modify-write updates and reads, holds the result.
`default_nettype none
module prb_back #(
    parameter int ANIMALS = prb_pkg::ANIMALS_DEF
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire prb_pkg::t_cmd     i_q_head,
    input  wire logic              i_q_empty,
    output logic                   o_q_pop,
    output logic                   o_clearing,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output prb_pkg::t_out_beat     o_out_beat
);

    localparam int DEPTH = ANIMALS * ANIMALS;
    localparam int AW    = $clog2(DEPTH);
    localparam int VW    = prb_pkg::VAL_W;

    prb_pkg::t_state           r_state, n_state;
    logic [AW-1:0]             r_clr, n_clr;
    prb_pkg::t_cmd             r_cmd, n_cmd;
    logic [prb_pkg::OPS_W-1:0] r_idx, n_idx;
    logic                      r_sat, n_sat;
    logic signed [VW-1:0]      r_val, n_val;
    logic                      r_out_valid, n_out_valid;
    prb_pkg::t_out_beat        r_out, n_out;

    prb_pkg::t_op              op;
    logic [prb_pkg::IDX_W-1:0] lo;
    logic [prb_pkg::IDX_W-1:0] hi;
    logic [AW-1:0]             op_addr;
    logic                      we;
    logic [AW-1:0]             waddr;
    logic signed [VW-1:0]      wdata;
    logic signed [VW-1:0]      rdata;
    logic signed [VW:0]        sum;

    prb_ram #(.WIDTH(VW), .DEPTH(DEPTH)) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (op_addr),
        .o_rdata (rdata)
    );

    // store stays symmetric, so only the (min, max) entry is kept current
    always_comb begin
        op      = r_cmd.ops[r_idx];
        lo      = (op.a < op.b) ? op.a : op.b;
        hi      = (op.a < op.b) ? op.b : op.a;
        op_addr = AW'(AW'(lo) * AW'(ANIMALS) + AW'(hi));
        sum     = {rdata[VW-1], rdata} + (VW+1)'(op.delta);
    end

    assign o_clearing  = r_state == prb_pkg::ST_CLEAR;
    assign o_out_valid = r_out_valid;
    assign o_out_beat  = r_out;

    always_comb begin
        n_state     = r_state;
        n_clr       = r_clr;
        n_cmd       = r_cmd;
        n_idx       = r_idx;
        n_sat       = r_sat;
        n_val       = r_val;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        o_q_pop     = 1'b0;
        we          = 1'b0;
        waddr       = op_addr;
        wdata       = '0;
        case (r_state)
            prb_pkg::ST_CLEAR: begin
                we    = 1'b1;
                waddr = r_clr;
                n_clr = r_clr + AW'(1);
                if (r_clr == AW'(DEPTH - 1)) begin
                    n_state = prb_pkg::ST_IDLE;
                end
            end
            prb_pkg::ST_IDLE: begin
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_cmd   = i_q_head;
                    n_idx   = '0;
                    n_sat   = 1'b0;
                    n_val   = '0;
                    case (i_q_head.kind)
                        prb_pkg::K_ZERO: n_state = prb_pkg::ST_DONE;
                        prb_pkg::K_SET:  n_state = prb_pkg::ST_WR;
                        default:         n_state = prb_pkg::ST_RD;
                    endcase
                end
            end
            prb_pkg::ST_RD: begin
                n_state = (r_cmd.kind == prb_pkg::K_READ) ? prb_pkg::ST_RDDATA
                                                           : prb_pkg::ST_WR;
            end
            prb_pkg::ST_RDDATA: begin
                n_val   = rdata;
                n_state = prb_pkg::ST_DONE;
            end
            prb_pkg::ST_WR: begin
                we = 1'b1;
                if (r_cmd.kind == prb_pkg::K_SET) begin
                    wdata   = prb_pkg::VAL_ONE;
                    n_state = prb_pkg::ST_DONE;
                end else begin
                    if (sum > (VW+1)'(prb_pkg::VAL_MAX)) begin
                        wdata = prb_pkg::VAL_MAX;
                        n_sat = 1'b1;
                    end else if (sum < (VW+1)'(prb_pkg::VAL_MIN)) begin
                        wdata = prb_pkg::VAL_MIN;
                        n_sat = 1'b1;
                    end else begin
                        wdata = sum[VW-1:0];
                    end
                    if (r_idx == r_cmd.last) begin
                        n_state = prb_pkg::ST_DONE;
                    end else begin
                        n_idx   = r_idx + prb_pkg::OPS_W'(1);
                        n_state = prb_pkg::ST_RD;
                    end
                end
            end
            prb_pkg::ST_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid           = 1'b1;
                    n_out.entry_value     = r_val;
                    n_out.saturated       = r_sat;
                    n_state               = prb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = prb_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= prb_pkg::ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd <= n_cmd;
        r_idx <= n_idx;
        r_sat <= n_sat;
        r_val <= n_val;
        r_out <= n_out;
    end

endmodule
`default_nettype wire

### src/pedigree_inverse_relationship_builder.sv
// Top level of the inverse relationship matrix builder (no inbreeding).
// Input channel: i_in_valid / o_in_stall / i_in_beat. A beat either applies one pedigree
// record to the ANIMALS x ANIMALS store (entries in sixths) or reads one entry.
// Output channel: o_out_valid / i_out_stall / o_out_beat, exactly one beat per input beat,
// in order. Reads return the entry; records return zero plus the saturation flag.
// A front end classifies each beat into a command list and pushes it into a two-entry
// queue; the back end runs the commands against one single-port-write store memory.
// The back end runs each memory update as one read-modify-write (a read state, then a
// write state); a record with both parents known makes six updates, one parent three,
// a founder one plain write, a read one memory read; ignored beats make no access.
// After reset the store is cleared one entry per cycle, all ANIMALS*ANIMALS entries
// (4096 at the default), with o_in_stall high the whole time.
// The result sits in an output register; while the receiver stalls, the back end can
// finish the next command but holds it until the register frees, and the queue keeps
// taking beats until it fills.
`default_nettype none
module pedigree_inverse_relationship_builder #(
    parameter int ANIMALS = prb_pkg::ANIMALS_DEF
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire prb_pkg::t_in_beat  i_in_beat,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output prb_pkg::t_out_beat      o_out_beat
);

    prb_pkg::t_cmd cmd;
    prb_pkg::t_cmd q_head;
    logic          q_empty;
    logic          q_full;
    logic          q_pop;
    logic          clearing;
    logic          push;

    assign o_in_stall = q_full || clearing;
    assign push       = i_in_valid && !o_in_stall;

    prb_front #(.ANIMALS(ANIMALS)) u_front (
        .i_beat (i_in_beat),
        .o_cmd  (cmd)
    );

    prb_cmd_fifo #(.DEPTH(prb_pkg::CMDQ_DEPTH)) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (q_pop),
        .o_head  (q_head),
        .o_empty (q_empty),
        .o_full  (q_full)
    );

    prb_back #(.ANIMALS(ANIMALS)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_head    (q_head),
        .i_q_empty   (q_empty),
        .o_q_pop     (q_pop),
        .o_clearing  (clearing),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat)
    );

endmodule
`default_nettype wire
